/* hw/rtl/css_pkg.sv */
// shared types and constants of the cursor sequence store
package css_pkg;

  // operation codes
  localparam logic [3:0] OP_START        = 4'd0;
  localparam logic [3:0] OP_END          = 4'd1;
  localparam logic [3:0] OP_LAST         = 4'd2;
  localparam logic [3:0] OP_ADVANCE      = 4'd3;
  localparam logic [3:0] OP_RETREAT      = 4'd4;
  localparam logic [3:0] OP_INSERT       = 4'd5;
  localparam logic [3:0] OP_ATTACH       = 4'd6;
  localparam logic [3:0] OP_REMOVE       = 4'd7;
  localparam logic [3:0] OP_FRONT_INSERT = 4'd8;
  localparam logic [3:0] OP_APPEND       = 4'd9;
  localparam logic [3:0] OP_REMOVE_FRONT = 4'd10;
  localparam logic [3:0] OP_READ         = 4'd11;

  // status codes
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_FULL     = 2'd1;
  localparam logic [1:0] STATUS_NO_ITEM  = 2'd2;
  localparam logic [1:0] STATUS_BAD_IDX  = 2'd3;

  // controller to datapath commands
  typedef struct packed {
    logic accept;   // latch the new transaction
    logic move_rd;  // read the entry at the move pointer
    logic move_wr;  // write the moved entry to its neighbor
    logic load;     // write the new data word
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic need_move;   // decoded transaction shifts entries
    logic need_write;  // current transaction stores a new word
    logic move_last;   // move pointer has reached its final entry
  } sts_t;

endpackage

/* hw/rtl/css_ram.sv */
// generic single write port ram with registered read
module css_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/css_ctrl.sv */
// sequencing state machine of the cursor sequence store
module css_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  css_pkg::sts_t sts,
  output css_pkg::cmd_t cmd,
  output logic          busy,
  output logic          out_valid
);

  typedef enum logic [5:0] {
    ST_IDLE    = 6'b000001,
    ST_MOVE_RD = 6'b000010,
    ST_MOVE_WR = 6'b000100,
    ST_LOAD    = 6'b001000,
    ST_FETCH   = 6'b010000,
    ST_DONE    = 6'b100000
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   accept;

  assign accept = start && (state_r == ST_IDLE);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (sts.need_move) begin
            state_nxt = ST_MOVE_RD;
          end else if (sts.need_write) begin
            state_nxt = ST_LOAD;
          end else begin
            state_nxt = ST_FETCH;
          end
        end
      end
      ST_MOVE_RD: state_nxt = ST_MOVE_WR;
      ST_MOVE_WR: begin
        if (!sts.move_last) begin
          state_nxt = ST_MOVE_RD;
        end else if (sts.need_write) begin
          state_nxt = ST_LOAD;
        end else begin
          state_nxt = ST_FETCH;
        end
      end
      ST_LOAD:  state_nxt = ST_FETCH;
      ST_FETCH: state_nxt = ST_DONE;
      ST_DONE:  state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // commands and handshake
  assign cmd.accept  = accept;
  assign cmd.move_rd = (state_r == ST_MOVE_RD);
  assign cmd.move_wr = (state_r == ST_MOVE_WR);
  assign cmd.load    = (state_r == ST_LOAD);
  assign busy        = (state_r != ST_IDLE);
  assign out_valid   = (state_r == ST_DONE);

endmodule

/* hw/rtl/css_datapath.sv */
// list state, entry shifting and result formation
module css_datapath #(
  parameter int CAPACITY   = 32,
  parameter int DATA_WIDTH = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  css_pkg::cmd_t cmd,
  output css_pkg::sts_t sts,
  input  logic [3:0]    in_opcode,
  input  logic [31:0]   in_entry_value,
  input  logic [4:0]    in_read_index,
  output logic [31:0]   out_item_value,
  output logic [5:0]    out_item_count,
  output logic [4:0]    out_cursor_pos,
  output logic          out_has_item,
  output logic [1:0]    out_status
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  // architectural state
  logic [CW-1:0]         count_r;
  logic [AW-1:0]         cursor_r;
  logic [1:0]            status_r;
  logic                  vok_r;
  // move and write bookkeeping
  logic [AW-1:0]         ptr_r;
  logic [AW-1:0]         lim_r;
  logic                  up_r;
  logic                  write_r;
  logic [AW-1:0]         wpos_r;
  logic [DATA_WIDTH-1:0] wdata_r;
  logic [AW-1:0]         faddr_r;

  // decode of the incoming transaction
  logic [CW-1:0] c;
  logic [CW-1:0] c_dec;
  logic [AW-1:0] k;
  logic          present;
  logic          full;
  logic [CW-1:0] nc;
  logic [AW-1:0] nk;
  logic [1:0]    st;
  logic          do_move;
  logic          up;
  logic [AW-1:0] ptr_init;
  logic [AW-1:0] lim;
  logic          do_write;
  logic [AW-1:0] wpos;
  logic [AW-1:0] faddr;
  logic          vok;
  logic          is_read;

  // ram ports
  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [DATA_WIDTH-1:0] ram_wdata;
  logic [AW-1:0]         ram_raddr;
  logic [DATA_WIDTH-1:0] ram_rdata;

  assign c       = count_r;
  assign c_dec   = count_r - CW'(1);
  assign k       = cursor_r;
  assign present = CW'(k) < c;
  assign full    = (c == CW'(CAPACITY));

  // per-operation next count, cursor, status and shift plan
  always_comb begin
    nc       = c;
    nk       = k;
    st       = css_pkg::STATUS_OK;
    do_move  = 1'b0;
    up       = 1'b1;
    ptr_init = AW'(c_dec);
    lim      = '0;
    do_write = 1'b0;
    wpos     = '0;
    is_read  = 1'b0;
    case (in_opcode)
      css_pkg::OP_START: nk = '0;
      css_pkg::OP_END:   nk = (c != '0) ? AW'(c_dec) : '0;
      css_pkg::OP_LAST:  nk = AW'(CAPACITY - 1);
      css_pkg::OP_ADVANCE: begin
        if (!present) begin
          st = css_pkg::STATUS_NO_ITEM;
        end else if (k != AW'(CAPACITY - 1)) begin
          nk = k + AW'(1);
        end
      end
      css_pkg::OP_RETREAT: begin
        if (k != '0) begin
          nk = k - AW'(1);
        end
      end
      css_pkg::OP_INSERT: begin
        if (full) begin
          st = css_pkg::STATUS_FULL;
        end else begin
          lim      = present ? k : '0;
          do_move  = CW'(lim) < c;
          do_write = 1'b1;
          wpos     = lim;
          nk       = lim;
          nc       = c + CW'(1);
        end
      end
      css_pkg::OP_ATTACH: begin
        if (full) begin
          st = css_pkg::STATUS_FULL;
        end else begin
          do_write = 1'b1;
          nc       = c + CW'(1);
          if (!present) begin
            wpos = AW'(c);
            nk   = AW'(c);
          end else begin
            lim     = k + AW'(1);
            do_move = CW'(lim) < c;
            wpos    = lim;
            nk      = lim;
          end
        end
      end
      css_pkg::OP_REMOVE: begin
        if (!present) begin
          st = css_pkg::STATUS_NO_ITEM;
        end else begin
          up       = 1'b0;
          ptr_init = k + AW'(1);
          lim      = AW'(c_dec);
          do_move  = (CW'(k) + CW'(1)) < c;
          nc       = c_dec;
          nk       = (CW'(k) >= c_dec) ? '0 : k;
        end
      end
      css_pkg::OP_FRONT_INSERT: begin
        if (full) begin
          st = css_pkg::STATUS_FULL;
        end else begin
          do_move  = (c != '0);
          do_write = 1'b1;
          nk       = '0;
          nc       = c + CW'(1);
        end
      end
      css_pkg::OP_APPEND: begin
        if (full) begin
          st = css_pkg::STATUS_FULL;
        end else begin
          do_write = 1'b1;
          wpos     = AW'(c);
          nk       = AW'(c);
          nc       = c + CW'(1);
        end
      end
      css_pkg::OP_REMOVE_FRONT: begin
        nk = '0;
        if (c == '0) begin
          st = css_pkg::STATUS_NO_ITEM;
        end else begin
          up       = 1'b0;
          ptr_init = AW'(1);
          lim      = AW'(c_dec);
          do_move  = c > CW'(1);
          nc       = c_dec;
        end
      end
      css_pkg::OP_READ: begin
        is_read = 1'b1;
        if (32'(in_read_index) >= 32'(c)) begin
          st = css_pkg::STATUS_BAD_IDX;
        end
      end
      default: ;
    endcase
  end

  // address and validity of the reported entry
  always_comb begin
    if (is_read) begin
      faddr = AW'(in_read_index);
      vok   = 32'(in_read_index) < 32'(c);
    end else begin
      faddr = nk;
      vok   = CW'(nk) < nc;
    end
  end

  // control state: count and cursor
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      cursor_r <= '0;
      write_r  <= 1'b0;
    end else if (cmd.accept) begin
      count_r  <= nc;
      cursor_r <= nk;
      write_r  <= do_write;
    end
  end

  // transaction payload and move pointer
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      status_r <= st;
      vok_r    <= vok;
      ptr_r    <= ptr_init;
      lim_r    <= lim;
      up_r     <= up;
      wpos_r   <= wpos;
      wdata_r  <= DATA_WIDTH'(in_entry_value);
      faddr_r  <= faddr;
    end else if (cmd.move_wr) begin
      ptr_r <= up_r ? (ptr_r - AW'(1)) : (ptr_r + AW'(1));
    end
  end

  // ram port selection: moves read then write a neighbor, load writes the new word
  always_comb begin
    ram_we    = cmd.move_wr || cmd.load;
    ram_waddr = wpos_r;
    ram_wdata = wdata_r;
    if (cmd.move_wr) begin
      ram_waddr = up_r ? (ptr_r + AW'(1)) : (ptr_r - AW'(1));
      ram_wdata = ram_rdata;
    end
    ram_raddr = cmd.move_rd ? ptr_r : faddr_r;
  end

  css_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // status to the controller: decoded write while accepting, latched one afterwards
  assign sts.need_move  = do_move;
  assign sts.need_write = cmd.accept ? do_write : write_r;
  assign sts.move_last  = (ptr_r == lim_r);

  // result fields
  assign out_item_value = vok_r ? 32'(ram_rdata) : '0;
  assign out_item_count = 6'(count_r);
  assign out_cursor_pos = 5'(cursor_r);
  assign out_has_item   = CW'(cursor_r) < count_r;
  assign out_status     = status_r;

endmodule

/* hw/rtl/cursor_sequence_store_top.sv */
// top level of the cursor sequence store
//
//   channel  handshake           fields
//   input    start & !busy       in_opcode, in_entry_value, in_read_index
//   result   out_valid (1 cyc)   out_item_value, out_item_count, out_cursor_pos,
//                                out_has_item, out_status
//
// one transaction at a time; each accepted start passes through the MOVE_RD and MOVE_WR
// states once per shifted entry (up to count), LOAD when a word is stored, then FETCH and DONE.
// the entry ram has a registered read port, so each shifted entry costs a read and a write.
// out_valid is raised in DONE, which follows FETCH; the receiver cannot stall.
// rst_n is synchronous: count and cursor clear, ram contents are left as they are.
module cursor_sequence_store_top #(
  parameter int CAPACITY   = 32,
  parameter int DATA_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [3:0]  in_opcode,
  input  logic [31:0] in_entry_value,
  input  logic [4:0]  in_read_index,
  output logic        out_valid,
  output logic [31:0] out_item_value,
  output logic [5:0]  out_item_count,
  output logic [4:0]  out_cursor_pos,
  output logic        out_has_item,
  output logic [1:0]  out_status
);

  css_pkg::cmd_t cmd;
  css_pkg::sts_t sts;

  // sequencer
  css_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  // list storage and bookkeeping
  css_datapath #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_opcode      (in_opcode),
    .in_entry_value (in_entry_value),
    .in_read_index  (in_read_index),
    .out_item_value (out_item_value),
    .out_item_count (out_item_count),
    .out_cursor_pos (out_cursor_pos),
    .out_has_item   (out_has_item),
    .out_status     (out_status)
  );

endmodule

/* verif/css_checker.sv */
`timescale 1ns / 1ps
// checker that predicts and compares every cursor sequence store result
module css_checker #(
  parameter int CAPACITY = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic [3:0]  in_opcode,
  input  logic [31:0] in_entry_value,
  input  logic [4:0]  in_read_index,
  input  logic        out_valid,
  input  logic [31:0] out_item_value,
  input  logic [5:0]  out_item_count,
  input  logic [4:0]  out_cursor_pos,
  input  logic        out_has_item,
  input  logic [1:0]  out_status,
  output int          fail_count,
  output int          pending,
  output int          level
);

  // one result of a list operation
  typedef struct packed {
    logic [31:0] value;
    logic [5:0]  count;
    logic [4:0]  cursor;
    logic        has_item;
    logic [1:0]  status;
  } list_result_t;

  // shadow copy of the list
  logic [31:0]  entries [CAPACITY];
  int unsigned  n_items;
  int unsigned  cur;
  list_result_t awaited_results [$];

  // move entries pos..n_items-1 up by one
  function automatic void open_gap(input int unsigned pos);
    for (int unsigned i = n_items; i > pos; i--)
      entries[i] = entries[i - 1];
  endfunction

  // move entries pos+1..n_items-1 down by one
  function automatic void close_gap(input int unsigned pos);
    for (int unsigned i = pos + 1; i < n_items; i++)
      entries[i - 1] = entries[i];
  endfunction

  // apply one operation to the shadow list and work out its result
  function automatic list_result_t run_list_op(input logic [3:0] op,
                                               input logic [31:0] val,
                                               input logic [4:0] idx);
    list_result_t r;
    logic [1:0]   st;
    logic         is_read;
    logic [31:0]  word;
    logic         full;
    logic         present;
    st      = css_pkg::STATUS_OK;
    is_read = 1'b0;
    word    = '0;
    full    = n_items >= CAPACITY;
    present = cur < n_items;
    case (op)
      css_pkg::OP_START: cur = 0;
      css_pkg::OP_END: cur = (n_items > 0) ? n_items - 1 : 0;
      css_pkg::OP_LAST: cur = CAPACITY - 1;
      css_pkg::OP_ADVANCE: begin
        if (!present) st = css_pkg::STATUS_NO_ITEM;
        else if (cur != CAPACITY - 1) cur++;
      end
      css_pkg::OP_RETREAT: begin
        if (cur != 0) cur--;
      end
      css_pkg::OP_INSERT: begin
        if (full) st = css_pkg::STATUS_FULL;
        else begin
          // no current item sends the word to the front
          if (!present) cur = 0;
          open_gap(cur);
          entries[cur] = val;
          n_items++;
        end
      end
      css_pkg::OP_ATTACH: begin
        if (full) st = css_pkg::STATUS_FULL;
        else begin
          // no current item appends at the end
          if (!present) begin
            entries[n_items] = val;
            cur = n_items;
          end else begin
            open_gap(cur + 1);
            entries[cur + 1] = val;
            cur++;
          end
          n_items++;
        end
      end
      css_pkg::OP_REMOVE: begin
        if (!present) st = css_pkg::STATUS_NO_ITEM;
        else begin
          close_gap(cur);
          n_items--;
          if (cur >= n_items) cur = 0;
        end
      end
      css_pkg::OP_FRONT_INSERT: begin
        if (full) st = css_pkg::STATUS_FULL;
        else begin
          open_gap(0);
          entries[0] = val;
          n_items++;
          cur = 0;
        end
      end
      css_pkg::OP_APPEND: begin
        if (full) st = css_pkg::STATUS_FULL;
        else begin
          entries[n_items] = val;
          cur = n_items;
          n_items++;
        end
      end
      css_pkg::OP_REMOVE_FRONT: begin
        cur = 0;
        if (n_items == 0) st = css_pkg::STATUS_NO_ITEM;
        else begin
          close_gap(0);
          n_items--;
        end
      end
      css_pkg::OP_READ: begin
        is_read = 1'b1;
        if (idx < n_items) word = entries[idx];
        else st = css_pkg::STATUS_BAD_IDX;
      end
      default: ;
    endcase
    if (!is_read && cur < n_items) word = entries[cur];
    r.value    = word;
    r.count    = 6'(n_items);
    r.cursor   = 5'(cur);
    r.has_item = cur < n_items;
    r.status   = st;
    return r;
  endfunction

  // compare one field of a result
  function automatic void check_field(input string name, input logic [31:0] want_v,
                                      input logic [31:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want_v, got_v);
      fail_count++;
    end
  endfunction

  // watch both channels at each rising edge
  always @(posedge clk) begin
    list_result_t want;
    if (!rst_n) begin
      n_items    = 0;
      cur        = 0;
      fail_count = 0;
      awaited_results.delete();
    end else begin
      // result transaction against the oldest prediction
      if (out_valid) begin
        if (awaited_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual value %0h count %0d",
                   $time, out_item_value, out_item_count);
          fail_count++;
        end else begin
          want = awaited_results.pop_front();
          check_field("item_value", want.value, out_item_value);
          check_field("item_count", want.count, out_item_count);
          check_field("cursor_pos", want.cursor, out_cursor_pos);
          check_field("has_item", want.has_item, out_has_item);
          check_field("status", want.status, out_status);
        end
      end
      // input transaction
      if (start && !busy)
        awaited_results.push_back(run_list_op(in_opcode, in_entry_value, in_read_index));
    end
    pending = awaited_results.size();
    level   = n_items;
  end

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps
// testbench top: stimulus, reset, clock and verdict for the cursor sequence store
module tb;

  localparam int CAPACITY  = 32;
  localparam int N_RANDOM  = 550;
  localparam int MAX_CYCLE = 200000;

  typedef enum logic [1:0] {MODE_GROW, MODE_HOLD, MODE_DRAIN} walk_mode_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [3:0]  in_opcode;
  logic [31:0] in_entry_value;
  logic [4:0]  in_read_index;
  logic        out_valid;
  logic [31:0] out_item_value;
  logic [5:0]  out_item_count;
  logic [4:0]  out_cursor_pos;
  logic        out_has_item;
  logic [1:0]  out_status;
  int          fail_count;
  int          pending;
  int          level;
  int          cycle_count;

  cursor_sequence_store_top #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (32)
  ) u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_opcode      (in_opcode),
    .in_entry_value (in_entry_value),
    .in_read_index  (in_read_index),
    .out_valid      (out_valid),
    .out_item_value (out_item_value),
    .out_item_count (out_item_count),
    .out_cursor_pos (out_cursor_pos),
    .out_has_item   (out_has_item),
    .out_status     (out_status)
  );

  css_checker #(
    .CAPACITY (CAPACITY)
  ) u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_opcode      (in_opcode),
    .in_entry_value (in_entry_value),
    .in_read_index  (in_read_index),
    .out_valid      (out_valid),
    .out_item_value (out_item_value),
    .out_item_count (out_item_count),
    .out_cursor_pos (out_cursor_pos),
    .out_has_item   (out_has_item),
    .out_status     (out_status),
    .fail_count     (fail_count),
    .pending        (pending),
    .level          (level)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // run limit
  initial begin
    cycle_count = 0;
    while (cycle_count < MAX_CYCLE) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("cursor_sequence_store_top test failed");
    $finish;
  end

  // drive one transaction and hold it until accepted
  task automatic send_op(input logic [3:0] op, input logic [31:0] val,
                         input logic [4:0] idx);
    start          <= 1'b1;
    in_opcode      <= op;
    in_entry_value <= val;
    in_read_index  <= idx;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  // idle the input with junk on the fields
  task automatic pause(input int n);
    if (n > 0) begin
      start          <= 1'b0;
      in_opcode      <= 4'($urandom);
      in_entry_value <= $urandom;
      in_read_index  <= 5'($urandom);
      repeat (n) @(negedge clk);
    end
  endtask

  // data word with extra weight on the extremes
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // read index, half of them below the current count
  function automatic logic [4:0] pick_index();
    if (level > 0 && $urandom_range(0, 1) == 0)
      return 5'($urandom_range(0, level - 1));
    return 5'($urandom_range(0, CAPACITY - 1));
  endfunction

  // operation mix that depends on whether the list is filling or draining
  function automatic logic [3:0] pick_op(input walk_mode_t mode);
    int roll;
    roll = $urandom_range(0, 99);
    case (mode)
      MODE_GROW: begin
        if (roll < 60) begin
          case ($urandom_range(0, 3))
            0:       return css_pkg::OP_INSERT;
            1:       return css_pkg::OP_ATTACH;
            2:       return css_pkg::OP_FRONT_INSERT;
            default: return css_pkg::OP_APPEND;
          endcase
        end
        if (roll < 85) return css_pkg::OP_START + 4'($urandom_range(0, 4));
        if (roll < 95) return css_pkg::OP_READ;
        if (roll < 98)
          return $urandom_range(0, 1) ? css_pkg::OP_REMOVE : css_pkg::OP_REMOVE_FRONT;
        return 4'($urandom_range(css_pkg::OP_READ + 1, 15));
      end
      MODE_DRAIN: begin
        if (roll < 55)
          return $urandom_range(0, 1) ? css_pkg::OP_REMOVE : css_pkg::OP_REMOVE_FRONT;
        if (roll < 80) return css_pkg::OP_START + 4'($urandom_range(0, 4));
        if (roll < 95) return css_pkg::OP_READ;
        return 4'($urandom_range(css_pkg::OP_INSERT, 15));
      end
      default: return 4'($urandom_range(0, 15));
    endcase
  endfunction

  // stimulus and verdict
  initial begin
    walk_mode_t mode;
    int         target;
    int         hold_left;
    int         burst_left;

    start          = 1'b0;
    in_opcode      = css_pkg::OP_START;
    in_entry_value = '0;
    in_read_index  = '0;
    rst_n          = 1'b0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty list corner cases
    send_op(css_pkg::OP_REMOVE_FRONT, 32'h0, 5'd0);
    send_op(css_pkg::OP_ADVANCE, 32'h0, 5'd0);
    send_op(css_pkg::OP_REMOVE, 32'h0, 5'd0);
    send_op(css_pkg::OP_READ, 32'h0, 5'd0);
    send_op(css_pkg::OP_END, 32'h0, 5'd0);
    send_op(css_pkg::OP_RETREAT, 32'h0, 5'd0);
    send_op(css_pkg::OP_LAST, 32'h0, 5'd0);
    // insert with no item goes to the front, then attach after it
    send_op(css_pkg::OP_INSERT, 32'h0000_0000, 5'd0);
    send_op(css_pkg::OP_ATTACH, 32'hffff_ffff, 5'd0);
    // attach with no item goes to the end
    send_op(css_pkg::OP_LAST, 32'h0, 5'd0);
    send_op(css_pkg::OP_ATTACH, 32'h5a5a_a5a5, 5'd0);
    send_op(css_pkg::OP_FRONT_INSERT, 32'h0000_0001, 5'd0);
    send_op(css_pkg::OP_APPEND, 32'h8000_0000, 5'd0);
    send_op(css_pkg::OP_START, 32'h0, 5'd0);
    send_op(css_pkg::OP_ADVANCE, 32'h0, 5'd0);
    send_op(css_pkg::OP_INSERT, 32'h1234_5678, 5'd0);
    // removing the last entry sends the cursor home
    send_op(css_pkg::OP_END, 32'h0, 5'd0);
    send_op(css_pkg::OP_REMOVE, 32'h0, 5'd0);
    send_op(css_pkg::OP_READ, 32'h0, 5'd31);
    send_op(css_pkg::OP_READ, 32'h0, 5'd0);
    send_op(css_pkg::OP_RETREAT, 32'h0, 5'd0);
    // undefined opcodes
    for (int op = css_pkg::OP_READ + 1; op < 16; op++)
      send_op(4'(op), $urandom, 5'($urandom));
    send_op(css_pkg::OP_REMOVE_FRONT, 32'h0, 5'd0);

    // random walk: fill, dwell, drain, in bursts with random gaps
    mode       = MODE_GROW;
    target     = ($urandom_range(0, 2) == 0) ? $urandom_range(4, CAPACITY) : CAPACITY;
    hold_left  = 0;
    burst_left = $urandom_range(1, 40);
    for (int sent = 0; sent < N_RANDOM; sent++) begin
      if (mode == MODE_GROW && level >= target) begin
        mode      = MODE_HOLD;
        hold_left = $urandom_range(8, 24);
      end else if (mode == MODE_HOLD && hold_left == 0) begin
        mode = MODE_DRAIN;
      end else if (mode == MODE_DRAIN && level == 0) begin
        mode   = MODE_GROW;
        target = ($urandom_range(0, 2) == 0) ? $urandom_range(4, CAPACITY) : CAPACITY;
      end
      if (mode == MODE_HOLD) hold_left--;
      send_op(pick_op(mode), pick_value(), pick_index());
      burst_left--;
      if (burst_left == 0) begin
        pause($urandom_range(1, 12));
        burst_left = $urandom_range(1, 40);
      end
    end
    pause(1);

    // drain outstanding results, then watch for strays
    while (pending != 0) @(negedge clk);
    repeat (80) @(negedge clk);

    if (fail_count == 0)
      $display("cursor_sequence_store_top test passed");
    else
      $display("cursor_sequence_store_top test failed");
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/css_pkg.sv
hw/rtl/css_ram.sv
hw/rtl/css_ctrl.sv
hw/rtl/css_datapath.sv
hw/rtl/cursor_sequence_store_top.sv
verif/css_checker.sv
verif/tb.sv
